// ----- design/terminal_key_event_encoder_defines.svh -----
// Assertion macros for the key event encoder checkers.
// Each macro expects clk, and all but TKEE_CHK_RST expect rst_n, to be visible where used.
`ifndef TERMINAL_KEY_EVENT_ENCODER_DEFINES_SVH
`define TERMINAL_KEY_EVENT_ENCODER_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define TKEE_CHK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define TKEE_CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that also looks at reset behavior.
`define TKEE_CHK_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/tkee_pkg.sv -----
package tkee_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  // config register indexes
  localparam logic [1:0] CFG_MODIFY_LEVEL = 2'd0;
  localparam logic [1:0] CFG_APP_KEYPAD   = 2'd1;
  localparam logic [1:0] CFG_APP_CURSOR   = 2'd2;

  // modify levels
  localparam logic [1:0] LVL_LEGACY = 2'd0;
  localparam logic [1:0] LVL_MOK1   = 2'd1;
  localparam logic [1:0] LVL_MOK2   = 2'd2;
  localparam logic [1:0] LVL_CSIU   = 2'd3;

  // key codes
  localparam logic [5:0] KEY_NONE     = 6'd0;
  localparam logic [5:0] KEY_LAST_CUR = 6'd6;
  localparam logic [5:0] KEY_INSERT   = 6'd7;
  localparam logic [5:0] KEY_PGDN     = 6'd10;
  localparam logic [5:0] KEY_F1       = 6'd11;
  localparam logic [5:0] KEY_F5       = 6'd15;
  localparam logic [5:0] KEY_ENTER    = 6'd23;
  localparam logic [5:0] KEY_TAB      = 6'd24;
  localparam logic [5:0] KEY_BKSP     = 6'd25;
  localparam logic [5:0] KEY_ESC      = 6'd26;
  localparam logic [5:0] KEY_SPACE    = 6'd27;
  localparam logic [5:0] KEY_KP_FIRST = 6'd28;
  localparam logic [5:0] KEY_KP_ENTER = 6'd44;

  // bytes
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] BYTE_SS3   = 8'h4F;  // 'O'
  localparam logic [7:0] BYTE_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] BYTE_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] BYTE_TILDE = 8'h7E;
  localparam logic [7:0] BYTE_U     = 8'h75;  // 'u'
  localparam logic [7:0] BYTE_Z     = 8'h5A;  // 'Z'
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_SP    = 8'h20;
  localparam logic [7:0] BYTE_NUL   = 8'h00;

  localparam logic [6:0] NUM_CSI27 = 7'd27;
  localparam logic [6:0] NUM_CR    = 7'd13;
  localparam logic [6:0] NUM_TAB   = 7'd9;
  localparam logic [6:0] NUM_DEL   = 7'd127;
  localparam logic [6:0] NUM_ESC   = 7'd27;
  localparam logic [6:0] NUM_ONE   = 7'd1;

  typedef enum logic [1:0] {
    INTRO_NONE,
    INTRO_CSI,
    INTRO_SS3
  } intro_t;

  // one decimal field, most significant digit in dig[0]
  typedef struct packed {
    logic [1:0]      ndig;
    logic [2:0][3:0] dig;
  } num_t;

  // sequence template: [ESC] [intro] [num {; num}] final
  typedef struct packed {
    logic            esc;
    intro_t          intro;
    logic [1:0]      nnum;
    num_t [2:0]      num;
    logic [7:0]      fin;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ESC,
    BK_INTRO,
    BK_DIGIT,
    BK_SEMI,
    BK_FINAL
  } bk_state_t;

  // values below 128 to decimal digits; tens by reciprocal multiply
  function automatic num_t to_dec(input logic [6:0] v);
    logic        hund;
    logic [6:0]  r;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    num_t        n;
    hund = (v >= 7'd100);
    r    = hund ? 7'(v - 7'd100) : v;
    prod = 15'(r) * 15'd205;
    tens = prod[14:11];
    ones = 4'(r - 7'(7'(tens) * 7'd10));
    n    = '0;
    if (hund) begin
      n.ndig   = 2'd3;
      n.dig[0] = 4'd1;
      n.dig[1] = tens;
      n.dig[2] = ones;
    end else if (v >= 7'd10) begin
      n.ndig   = 2'd2;
      n.dig[0] = tens;
      n.dig[1] = ones;
    end else begin
      n.ndig   = 2'd1;
      n.dig[0] = ones;
    end
    return n;
  endfunction

  function automatic logic [7:0] cursor_final(input logic [2:0] i);
    case (i)
      3'd0:    return 8'h41;  // A
      3'd1:    return 8'h42;  // B
      3'd2:    return 8'h43;  // C
      3'd3:    return 8'h44;  // D
      3'd4:    return 8'h48;  // H
      default: return 8'h46;  // F
    endcase
  endfunction

  function automatic logic [6:0] edit_code(input logic [1:0] i);
    case (i)
      2'd0:    return 7'd2;
      2'd1:    return 7'd3;
      2'd2:    return 7'd5;
      default: return 7'd6;
    endcase
  endfunction

  function automatic logic [7:0] fkey_final(input logic [1:0] i);
    case (i)
      2'd0:    return 8'h50;  // P
      2'd1:    return 8'h51;  // Q
      2'd2:    return 8'h52;  // R
      default: return 8'h53;  // S
    endcase
  endfunction

  function automatic logic [6:0] fkey_code(input logic [2:0] i);
    case (i)
      3'd0:    return 7'd15;
      3'd1:    return 7'd17;
      3'd2:    return 7'd18;
      3'd3:    return 7'd19;
      3'd4:    return 7'd20;
      3'd5:    return 7'd21;
      3'd6:    return 7'd23;
      default: return 7'd24;
    endcase
  endfunction

  function automatic logic [6:0] text_ucs(input logic [2:0] i);
    case (i)
      3'd0:    return 7'd13;
      3'd1:    return 7'd9;
      3'd2:    return 7'd127;
      3'd3:    return 7'd27;
      default: return 7'd32;
    endcase
  endfunction

  function automatic logic [6:0] csiu_fn_code(input logic [4:0] i);
    case (i)
      5'd0:    return 7'd1;
      5'd1:    return 7'd2;
      5'd2:    return 7'd3;
      5'd3:    return 7'd4;
      5'd4:    return 7'd7;
      5'd5:    return 7'd8;
      5'd6:    return 7'd2;
      5'd7:    return 7'd3;
      5'd8:    return 7'd5;
      5'd9:    return 7'd6;
      5'd10:   return 7'd13;
      5'd11:   return 7'd14;
      5'd12:   return 7'd15;
      5'd13:   return 7'd16;
      5'd14:   return 7'd17;
      5'd15:   return 7'd18;
      5'd16:   return 7'd19;
      5'd17:   return 7'd20;
      5'd18:   return 7'd21;
      5'd19:   return 7'd22;
      5'd20:   return 7'd23;
      default: return 7'd24;
    endcase
  endfunction

  function automatic logic [7:0] kp_num(input logic [4:0] i);
    case (i)
      5'd10:   return 8'h2E;  // .
      5'd11:   return 8'h2F;  // /
      5'd12:   return 8'h2A;  // *
      5'd13:   return 8'h2D;  // -
      5'd14:   return 8'h2B;  // +
      5'd15:   return 8'h2C;  // ,
      5'd16:   return 8'h0D;  // keypad Enter
      default: return 8'(8'h30 + 8'(i));
    endcase
  endfunction

  function automatic logic [7:0] kp_app(input logic [4:0] i);
    case (i)
      5'd10:   return 8'h6E;  // n
      5'd11:   return 8'h6F;  // o
      5'd12:   return 8'h6A;  // j
      5'd13:   return 8'h6B;  // k
      5'd14:   return 8'h6C;  // l
      5'd15:   return 8'h6C;  // l
      5'd16:   return 8'h4D;  // M
      default: return 8'(8'h70 + 8'(i));
    endcase
  endfunction

endpackage

// ----- design/tkee_queue.sv -----
module tkee_queue #(
  parameter int DEPTH = tkee_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  tkee_pkg::desc_t     wr_data,
  input  logic                rd_en,
  output tkee_pkg::desc_t     rd_data,
  output tkee_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tkee_pkg::desc_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == CW'(DEPTH));
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- design/tkee_front.sv -----
module tkee_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [1:0]          cfg_data,
  input  logic                start,
  output logic                busy,
  input  logic [5:0]          in_key_code,
  input  logic                in_mod_shift,
  input  logic                in_mod_alt,
  input  logic                in_mod_ctrl,
  input  logic                in_mod_meta,
  input  tkee_pkg::q_status_t q_status,
  output logic                push,
  output tkee_pkg::desc_t     desc
);

  logic [1:0] modify_level_r, modify_level_nxt;
  logic       app_keypad_r, app_keypad_nxt;
  logic       app_cursor_r, app_cursor_nxt;

  logic            any, esc, is_text, is_kp, known, enc;
  logic [4:0]      mp, mp1;
  logic [5:0]      kk;
  logic [4:0]      kp_idx;
  logic [6:0]      n0, n1, n2;
  tkee_pkg::desc_t d;

  // config registers
  always_comb begin
    modify_level_nxt = modify_level_r;
    app_keypad_nxt   = app_keypad_r;
    app_cursor_nxt   = app_cursor_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tkee_pkg::CFG_MODIFY_LEVEL: modify_level_nxt = cfg_data;
        tkee_pkg::CFG_APP_KEYPAD:   app_keypad_nxt   = cfg_data[0];
        tkee_pkg::CFG_APP_CURSOR:   app_cursor_nxt   = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modify_level_r <= tkee_pkg::LVL_LEGACY;
      app_keypad_r   <= 1'b0;
      app_cursor_r   <= 1'b0;
    end else begin
      modify_level_r <= modify_level_nxt;
      app_keypad_r   <= app_keypad_nxt;
      app_cursor_r   <= app_cursor_nxt;
    end
  end

  assign any     = in_mod_shift | in_mod_alt | in_mod_ctrl | in_mod_meta;
  assign esc     = in_mod_alt | in_mod_meta;
  assign mp      = 5'({1'b0, in_mod_meta, in_mod_ctrl, in_mod_alt, in_mod_shift} + 5'd1);
  assign mp1     = 5'(mp + 5'd1);
  assign is_text = (in_key_code >= tkee_pkg::KEY_ENTER) && (in_key_code <= tkee_pkg::KEY_SPACE);
  assign is_kp   = (in_key_code >= tkee_pkg::KEY_KP_FIRST)
                && (in_key_code <= tkee_pkg::KEY_KP_ENTER);
  assign known   = (in_key_code != tkee_pkg::KEY_NONE)
                && (in_key_code <= tkee_pkg::KEY_KP_ENTER);
  assign kp_idx  = 5'(in_key_code - tkee_pkg::KEY_KP_FIRST);
  // modified keypad Enter goes down the main Enter path
  assign kk      = (in_key_code == tkee_pkg::KEY_KP_ENTER) ? tkee_pkg::KEY_ENTER : in_key_code;

  // classification into a sequence template
  always_comb begin
    d     = '0;
    enc   = 1'b1;
    n0    = '0;
    n1    = '0;
    n2    = '0;
    if (!known) begin
      enc = 1'b0;
    end else if (modify_level_r == tkee_pkg::LVL_CSIU && any) begin
      d.intro = tkee_pkg::INTRO_CSI;
      d.nnum  = 2'd2;
      if (is_text) begin
        n0 = tkee_pkg::text_ucs(3'(in_key_code - tkee_pkg::KEY_ENTER));
      end else if (is_kp) begin
        n0 = 7'(tkee_pkg::kp_num(kp_idx));
      end else begin
        n0 = tkee_pkg::csiu_fn_code(5'(in_key_code - 6'd1));
      end
      n1    = 7'(mp1);
      d.fin = tkee_pkg::BYTE_U;
    end else if (modify_level_r == tkee_pkg::LVL_MOK2 && any
                 && (is_text || in_key_code == tkee_pkg::KEY_KP_ENTER)) begin
      d.intro = tkee_pkg::INTRO_CSI;
      d.nnum  = 2'd3;
      n0      = tkee_pkg::NUM_CSI27;
      n1      = 7'(mp);
      n2      = is_text ? tkee_pkg::text_ucs(3'(in_key_code - tkee_pkg::KEY_ENTER))
                        : tkee_pkg::NUM_CR;
      d.fin   = tkee_pkg::BYTE_TILDE;
    end else if (modify_level_r == tkee_pkg::LVL_MOK1 && (in_mod_ctrl || in_mod_alt)
                 && (in_key_code == tkee_pkg::KEY_ENTER || in_key_code == tkee_pkg::KEY_KP_ENTER
                     || in_key_code == tkee_pkg::KEY_TAB || in_key_code == tkee_pkg::KEY_BKSP
                     || in_key_code == tkee_pkg::KEY_ESC)) begin
      d.intro = tkee_pkg::INTRO_CSI;
      d.nnum  = 2'd3;
      n0      = tkee_pkg::NUM_CSI27;
      n1      = 7'(mp);
      case (in_key_code)
        tkee_pkg::KEY_TAB:  n2 = tkee_pkg::NUM_TAB;
        tkee_pkg::KEY_BKSP: n2 = tkee_pkg::NUM_DEL;
        tkee_pkg::KEY_ESC:  n2 = tkee_pkg::NUM_ESC;
        default:            n2 = tkee_pkg::NUM_CR;
      endcase
      d.fin   = tkee_pkg::BYTE_TILDE;
    end else if (is_kp && !(in_key_code == tkee_pkg::KEY_KP_ENTER && any)) begin
      if (!any) begin
        if (app_keypad_r) begin
          d.esc   = 1'b1;
          d.intro = tkee_pkg::INTRO_SS3;
          d.fin   = tkee_pkg::kp_app(kp_idx);
        end else begin
          d.fin   = tkee_pkg::kp_num(kp_idx);
        end
      end else if (in_mod_ctrl) begin
        enc = 1'b0;
      end else begin
        d.esc = esc;
        d.fin = tkee_pkg::kp_num(kp_idx);
      end
    end else if (kk == tkee_pkg::KEY_ENTER) begin
      d.esc = esc;
      d.fin = in_mod_ctrl ? tkee_pkg::BYTE_LF : tkee_pkg::BYTE_CR;
    end else if (kk == tkee_pkg::KEY_TAB) begin
      if (in_mod_shift && !in_mod_ctrl && !in_mod_alt && !in_mod_meta) begin
        d.esc   = 1'b1;
        d.intro = tkee_pkg::INTRO_CSI;
        d.fin   = tkee_pkg::BYTE_Z;
      end else begin
        d.esc = esc;
        d.fin = tkee_pkg::BYTE_TAB;
      end
    end else if (kk == tkee_pkg::KEY_BKSP) begin
      d.esc = esc;
      d.fin = in_mod_ctrl ? tkee_pkg::BYTE_BS : tkee_pkg::BYTE_DEL;
    end else if (kk == tkee_pkg::KEY_ESC) begin
      // a lone ESC, whatever modifiers are set when this branch is reached
      d.fin = tkee_pkg::BYTE_ESC;
    end else if (kk == tkee_pkg::KEY_SPACE) begin
      d.esc = esc;
      d.fin = in_mod_ctrl ? tkee_pkg::BYTE_NUL : tkee_pkg::BYTE_SP;
    end else if (kk <= tkee_pkg::KEY_LAST_CUR) begin
      d.esc = 1'b1;
      d.fin = tkee_pkg::cursor_final(3'(kk - 6'd1));
      if (any) begin
        d.intro = tkee_pkg::INTRO_CSI;
        d.nnum  = 2'd2;
        n0      = tkee_pkg::NUM_ONE;
        n1      = 7'(mp);
      end else begin
        d.intro = app_cursor_r ? tkee_pkg::INTRO_SS3 : tkee_pkg::INTRO_CSI;
      end
    end else if (kk <= tkee_pkg::KEY_PGDN || kk >= tkee_pkg::KEY_F5) begin
      d.esc   = 1'b1;
      d.intro = tkee_pkg::INTRO_CSI;
      d.nnum  = any ? 2'd2 : 2'd1;
      n0      = (kk <= tkee_pkg::KEY_PGDN)
                ? tkee_pkg::edit_code(2'(kk - tkee_pkg::KEY_INSERT))
                : tkee_pkg::fkey_code(3'(kk - tkee_pkg::KEY_F5));
      n1      = 7'(mp);
      d.fin   = tkee_pkg::BYTE_TILDE;
    end else begin
      // F1 to F4
      d.esc = 1'b1;
      d.fin = tkee_pkg::fkey_final(2'(kk - tkee_pkg::KEY_F1));
      if (any) begin
        d.intro = tkee_pkg::INTRO_CSI;
        d.nnum  = 2'd2;
        n0      = tkee_pkg::NUM_ONE;
        n1      = 7'(mp);
      end else begin
        d.intro = tkee_pkg::INTRO_SS3;
      end
    end
    // every escape sequence with an introducer starts with ESC
    if (d.intro != tkee_pkg::INTRO_NONE) begin
      d.esc = 1'b1;
    end
    d.num[0] = tkee_pkg::to_dec(n0);
    d.num[1] = tkee_pkg::to_dec(n1);
    d.num[2] = tkee_pkg::to_dec(n2);
  end

  assign busy = q_status.full;
  assign push = start && !q_status.full && enc;
  assign desc = d;

endmodule

// ----- design/tkee_back.sv -----
module tkee_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tkee_pkg::q_status_t q_status,
  input  tkee_pkg::desc_t     head,
  output logic                pop,
  output logic                out_strobe,
  output logic [7:0]          out_byte,
  output logic                out_last_byte
);

  tkee_pkg::bk_state_t state_r, state_nxt;
  tkee_pkg::desc_t     cur_r, cur_nxt;
  logic [1:0]          num_r, num_nxt;
  logic [1:0]          dig_r, dig_nxt;
  logic [3:0]          digit;

  function automatic tkee_pkg::bk_state_t after_intro(input tkee_pkg::desc_t d);
    return (d.nnum != 2'd0) ? tkee_pkg::BK_DIGIT : tkee_pkg::BK_FINAL;
  endfunction

  function automatic tkee_pkg::bk_state_t after_esc(input tkee_pkg::desc_t d);
    return (d.intro != tkee_pkg::INTRO_NONE) ? tkee_pkg::BK_INTRO : after_intro(d);
  endfunction

  function automatic tkee_pkg::bk_state_t first_state(input tkee_pkg::desc_t d);
    return d.esc ? tkee_pkg::BK_ESC : after_esc(d);
  endfunction

  assign digit = cur_r.num[num_r].dig[dig_r];

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    num_nxt       = num_r;
    dig_nxt       = dig_r;
    pop           = 1'b0;
    out_strobe    = 1'b1;
    out_last_byte = 1'b0;
    out_byte      = cur_r.fin;
    unique case (state_r)
      tkee_pkg::BK_IDLE: begin
        out_strobe = 1'b0;
      end
      tkee_pkg::BK_ESC: begin
        out_byte  = tkee_pkg::BYTE_ESC;
        state_nxt = after_esc(cur_r);
      end
      tkee_pkg::BK_INTRO: begin
        out_byte  = (cur_r.intro == tkee_pkg::INTRO_SS3) ? tkee_pkg::BYTE_SS3
                                                          : tkee_pkg::BYTE_LBRK;
        state_nxt = after_intro(cur_r);
      end
      tkee_pkg::BK_DIGIT: begin
        out_byte = tkee_pkg::BYTE_ZERO | {4'h0, digit};
        if (2'(dig_r + 2'd1) != cur_r.num[num_r].ndig) begin
          dig_nxt = 2'(dig_r + 2'd1);
        end else if (2'(num_r + 2'd1) != cur_r.nnum) begin
          state_nxt = tkee_pkg::BK_SEMI;
        end else begin
          state_nxt = tkee_pkg::BK_FINAL;
        end
      end
      tkee_pkg::BK_SEMI: begin
        out_byte  = tkee_pkg::BYTE_SEMI;
        num_nxt   = 2'(num_r + 2'd1);
        dig_nxt   = 2'd0;
        state_nxt = tkee_pkg::BK_DIGIT;
      end
      tkee_pkg::BK_FINAL: begin
        out_last_byte = 1'b1;
      end
      default: begin
        out_strobe = 1'b0;
        state_nxt  = tkee_pkg::BK_IDLE;
      end
    endcase
    // next item starts right behind the last byte of this one
    if (state_r == tkee_pkg::BK_IDLE || state_r == tkee_pkg::BK_FINAL) begin
      if (!q_status.empty) begin
        pop       = 1'b1;
        cur_nxt   = head;
        num_nxt   = 2'd0;
        dig_nxt   = 2'd0;
        state_nxt = first_state(head);
      end else begin
        state_nxt = tkee_pkg::BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tkee_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    num_r <= num_nxt;
    dig_r <= dig_nxt;
  end

endmodule

// ----- design/terminal_key_event_encoder.sv -----
// Key event to terminal byte sequence encoder.
// Input: a key event is taken at a clock edge with start high and busy low:
//   in_key_code plus the shift, alt, ctrl and meta flags. Unknown codes and
//   keys with no encoding are taken and produce nothing.
// Output: the sequence leaves one byte per cycle on out_byte, flagged by
//   out_strobe for exactly one cycle each; out_last_byte marks the final byte.
//   The receiver has no back-pressure: every strobed byte must be taken.
// Config: cfg_we / cfg_index / cfg_data write modify_level (0), app_keypad (1)
//   and app_cursor (2); write only while no item is in flight.
// Order: an accepted item is written into the queue, popped once the serializer is
//   idle or on its final byte, and then its bytes follow back to back.
// Throughput: an item has 1 to 12 bytes, sent by the one-byte-per-cycle output
//   serializer. The front classifies one item per cycle into a queue of
//   QUEUE_DEPTH sequence templates; busy is high only while that queue is
//   full, so short bursts are absorbed.
// Reset (rst_n low, synchronous): config back to legacy mode with both
//   application flags off, queue emptied, serializer idle, no strobe.
module terminal_key_event_encoder #(
  parameter int QUEUE_DEPTH = tkee_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // config write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data,
  // key event channel
  input  logic       start,
  output logic       busy,
  input  logic [5:0] in_key_code,
  input  logic       in_mod_shift,
  input  logic       in_mod_alt,
  input  logic       in_mod_ctrl,
  input  logic       in_mod_meta,
  // byte channel
  output logic       out_strobe,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);

  tkee_pkg::q_status_t q_status;
  tkee_pkg::desc_t     push_desc;
  tkee_pkg::desc_t     head_desc;
  logic                push;
  logic                pop;

  // front: config registers and key classification
  tkee_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .in_key_code  (in_key_code),
    .in_mod_shift (in_mod_shift),
    .in_mod_alt   (in_mod_alt),
    .in_mod_ctrl  (in_mod_ctrl),
    .in_mod_meta  (in_mod_meta),
    .q_status     (q_status),
    .push         (push),
    .desc         (push_desc)
  );

  // template queue between classification and serialization
  tkee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_desc),
    .rd_en   (pop),
    .rd_data (head_desc),
    .status  (q_status)
  );

  // back: walks a template one byte per cycle
  tkee_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .head          (head_desc),
    .pop           (pop),
    .out_strobe    (out_strobe),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

// ----- design/tkee_checker.sv -----
`include "terminal_key_event_encoder_defines.svh"

module tkee_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [7:0] out_byte,
  input logic       out_last_byte
);

  // bytes of one sequence come out without gaps
  `TKEE_CHK_NEXT(a_seq_contiguous, out_strobe && !out_last_byte, out_strobe, "gap inside sequence")

  // an ESC that opens a sequence is never followed by a second ESC
  `TKEE_CHK_NEXT(a_no_double_esc, out_strobe && !out_last_byte && out_byte == tkee_pkg::BYTE_ESC,
                 out_byte != tkee_pkg::BYTE_ESC, "ESC repeated inside sequence")

  // the queue only fills because an item was taken
  `TKEE_CHK(a_busy_after_accept, $rose(busy), $past(start && !busy), "busy rose without accept")

  // first cycle out of reset: nothing in flight
  `TKEE_CHK_RST(a_reset_clean, rst_n && $past(!rst_n), !out_strobe && !busy, "activity right after reset")

endmodule

bind terminal_key_event_encoder tkee_checker u_tkee_checker (.*);
